@@ hw/rtl/sent_packet_loss_tracker_assert.svh @@
// Assertion macros shared by the tracker RTL.
// SPL_ASSERT checks a property outside reset; SPL_ASSERT_ALWAYS checks it at every edge.
`ifndef SENT_PACKET_LOSS_TRACKER_ASSERT_SVH
`define SENT_PACKET_LOSS_TRACKER_ASSERT_SVH
`ifndef SYNTHESIS
`define SPL_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");
`define SPL_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");
`else
`define SPL_ASSERT(lbl, clk, rst_n, prop)
`define SPL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ hw/rtl/spl_pkg.sv @@
package spl_pkg;

	// field widths
	localparam int PN_W     = 62;
	localparam int SIZE_W   = 16;
	localparam int CMD_W    = 2;
	localparam int THR_W    = 8;
	localparam int FLIGHT_W = 22;
	localparam int BIF_W    = 21;
	localparam int LOST_W   = 6;
	localparam int STAT_W   = 2;

	localparam int SLOTS_DEF = 32;
	localparam logic [THR_W-1:0] THR_RESET = 8'd3;

	// command codes
	localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_LOSS = 2'd2;

	// slot status codes
	localparam logic [STAT_W-1:0] ST_INFLIGHT = 2'd0;
	localparam logic [STAT_W-1:0] ST_ACKED    = 2'd1;
	localparam logic [STAT_W-1:0] ST_LOST     = 2'd2;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SIZE_W-1:0] bytes;
		logic [PN_W-1:0]   number;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic              accepted;
		logic [LOST_W-1:0] lost_count;
		logic [BIF_W-1:0]  flight_sum;
		logic [PN_W-1:0]   max_acked_pn;
		logic              any_acked;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} seq_state_t;

endpackage

@@ hw/rtl/spl_if.sv @@
// command channel
interface spl_in_if import spl_pkg::*;;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [PN_W-1:0]   packet_number;
	logic [SIZE_W-1:0] packet_size;

	modport source (output valid, cmd, packet_number, packet_size, input ready);
	modport sink (input valid, cmd, packet_number, packet_size, output ready);
endinterface

// result channel
interface spl_out_if import spl_pkg::*;;
	logic              valid;
	logic              ready;
	logic              accepted;
	logic [LOST_W-1:0] lost_count;
	logic [BIF_W-1:0]  flight_sum;
	logic [PN_W-1:0]   max_acked_pn;
	logic              any_acked;

	modport source (output valid, accepted, lost_count, flight_sum, max_acked_pn,
		any_acked, input ready);
	modport sink (input valid, accepted, lost_count, flight_sum, max_acked_pn,
		any_acked, output ready);
endinterface

@@ hw/rtl/spl_ram.sv @@
module spl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/spl_engine.sv @@
`include "sent_packet_loss_tracker_assert.svh"

module spl_engine import spl_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	spl_in_if.sink           in_ch,
	input  logic [THR_W-1:0] threshold,
	output logic             res_valid,
	input  logic             res_ready,
	output result_t          res
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(SLOTS);

	seq_state_t state_q, state_d;

	logic [CMD_W-1:0]    cmd_q;
	logic [PN_W-1:0]     pn_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic [FLIGHT_W-1:0] flight_q;
	logic [PN_W-1:0]     top_q;
	logic                seen_q;
	logic                acc_q;
	logic                found_q;
	logic [LOST_W-1:0]   lost_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;

	logic                in_fire;
	logic                send_ok;
	logic                issue;
	logic                hit;
	logic                ack_take;
	logic                lose;
	logic [PN_W:0]       lose_bound;
	entry_t              rd_entry;
	logic [ENTRY_W-1:0]  rd_raw;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_waddr;
	entry_t              ram_wdata;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign send_ok     = (fill_q < SLOTS_C);

	// slot table: used slots are always the lowest fill_q entries
	spl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rd_raw)
	);

	assign rd_entry = entry_t'(rd_raw);

	// evaluate the entry read last cycle; each entry is read once and written
	// back at most once per scan, and a new command starts only after the
	// write-back, so no forwarding is needed
	assign lose_bound = {1'b0, rd_entry.number} + {{(PN_W + 1 - THR_W){1'b0}}, threshold};
	assign hit      = vld_s1 && (cmd_q == CMD_ACK) && !found_q && (rd_entry.number == pn_q);
	assign ack_take = hit && (rd_entry.status == ST_INFLIGHT);
	assign lose     = vld_s1 && (cmd_q == CMD_LOSS) && (rd_entry.status == ST_INFLIGHT) &&
		({1'b0, top_q} >= lose_bound);
	assign issue    = (state_q == S_SCAN) && (rd_idx_q < fill_q) && !found_q && !hit;

	// write port: new slot on send, status update on scan
	always_comb begin
		ram_we    = (in_fire && (in_ch.cmd == CMD_SEND) && send_ok) || ack_take || lose;
		ram_waddr = idx_s1;
		ram_wdata = rd_entry;
		ram_wdata.status = (cmd_q == CMD_ACK) ? ST_ACKED : ST_LOST;
		if (in_fire) begin
			ram_waddr        = fill_q[IDX_W-1:0];
			ram_wdata.status = ST_INFLIGHT;
			ram_wdata.bytes  = in_ch.packet_size;
			ram_wdata.number = in_ch.packet_number;
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and result handshake
	always_comb begin
		state_d   = state_q;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					if (in_ch.cmd == CMD_ACK && fill_q != '0) begin
						state_d = S_SCAN;
					end else if (in_ch.cmd == CMD_LOSS && seen_q && fill_q != '0) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_SCAN: begin
				if (!issue && !vld_s1) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// latch command payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= in_ch.cmd;
			pn_q  <= in_ch.packet_number;
		end
	end

	// update counters, totals and scan pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			rd_idx_q <= '0;
			flight_q <= '0;
			top_q    <= '0;
			seen_q   <= 1'b0;
			acc_q    <= 1'b0;
			found_q  <= 1'b0;
			lost_q   <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
		end else begin
			vld_s1 <= issue;
			idx_s1 <= rd_idx_q[IDX_W-1:0];
			if (in_fire) begin
				acc_q    <= 1'b0;
				found_q  <= 1'b0;
				lost_q   <= '0;
				rd_idx_q <= '0;
				case (in_ch.cmd)
					CMD_SEND: begin
						if (send_ok) begin
							fill_q   <= fill_q + CNT_W'(1);
							flight_q <= flight_q + {{(FLIGHT_W - SIZE_W){1'b0}},
								in_ch.packet_size};
							acc_q    <= 1'b1;
						end
					end
					CMD_ACK: begin
						if (!seen_q || in_ch.packet_number > top_q) begin
							top_q <= in_ch.packet_number;
						end
						seen_q <= 1'b1;
					end
					default: ;
				endcase
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + CNT_W'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
				if (ack_take) begin
					acc_q <= 1'b1;
				end
				if (ack_take || lose) begin
					flight_q <= flight_q - {{(FLIGHT_W - SIZE_W){1'b0}}, rd_entry.bytes};
				end
				if (lose && lost_q != '1) begin
					lost_q <= lost_q + LOST_W'(1);
				end
			end
		end
	end

	assign res.accepted     = acc_q;
	assign res.lost_count   = lost_q;
	assign res.flight_sum   = flight_q[BIF_W-1:0];
	assign res.max_acked_pn = top_q;
	assign res.any_acked    = seen_q;

	`SPL_ASSERT(a_full_send_refused, clk, arst_n,
		(in_fire && in_ch.cmd == CMD_SEND && fill_q == SLOTS_C) |=> $stable(fill_q))
	`SPL_ASSERT(a_no_read_at_result, clk, arst_n, res_valid |-> (!vld_s1 && !issue))
	`SPL_ASSERT(a_lost_only_on_loss, clk, arst_n,
		(res_valid && cmd_q != CMD_LOSS) |-> (lost_q == '0))

endmodule

@@ hw/rtl/sent_packet_loss_tracker.sv @@
// Sent-packet tracker with packet-threshold loss detection.
//
// in_ch carries one command per transaction: send (record packet number and
// size in the next free slot), ack (raise the largest acknowledged number and
// mark the matching in-flight packet acked) or loss (mark every in-flight
// packet at least the loss threshold below the largest acked as lost).
// out_ch returns one result transaction per command: accepted flag, lost
// count, bytes in flight, largest acked number and the any-acked flag.
// cfg_we/cfg_wdata write the loss threshold; write it only while idle.
//
// Sequence: a send goes from S_IDLE through S_DONE into the output register;
// ack and loss walk the used slots through the slot RAM at one read per cycle;
// an ack stops at the first matching slot. Commands are processed one at a
// time: the next one is accepted the cycle after a result is loaded.
// Reset empties the table, clears totals and restores the threshold to 3.
// The output register holds a result while out_ch is stalled; one further
// command is accepted and processed meanwhile, then waits for the register.
`include "sent_packet_loss_tracker_assert.svh"

module sent_packet_loss_tracker import spl_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	spl_in_if.sink           in_ch,
	spl_out_if.source        out_ch,
	input  logic             cfg_we,
	input  logic [THR_W-1:0] cfg_wdata
);

	logic [THR_W-1:0] threshold_q;
	logic             res_valid;
	logic             res_ready;
	result_t          res;
	logic             out_valid_q;
	result_t          out_q;

	// hold threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	spl_engine #(
		.SLOTS (SLOTS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.threshold (threshold_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register: load when empty or being drained
	assign res_ready = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.accepted     = out_q.accepted;
	assign out_ch.lost_count   = out_q.lost_count;
	assign out_ch.flight_sum   = out_q.flight_sum;
	assign out_ch.max_acked_pn = out_q.max_acked_pn;
	assign out_ch.any_acked    = out_q.any_acked;

	`SPL_ASSERT(a_cfg_write_lands, clk, arst_n, cfg_we |=> (threshold_q == $past(cfg_wdata)))
	`SPL_ASSERT(a_result_loaded, clk, arst_n, (res_valid && res_ready) |=> out_valid_q)
	`SPL_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> !out_valid_q)

endmodule
